// File: hdl/smt_pkg.sv
// Shared types, constants and tables for the swim motor target generator.
`default_nettype none
package smt_pkg;

  // configuration register indexes
  localparam logic [7:0] CFG_SIG_GAIN      = 8'd0;
  localparam logic [7:0] CFG_SIG_BIAS      = 8'd1;
  localparam logic [7:0] CFG_SEG_GAIN_0    = 8'd2;
  localparam logic [7:0] CFG_SEG_GAIN_LAST = 8'd7;

  localparam int GAIN_REGS = 6;

  // sine polynomial, Q14
  localparam logic [14:0] SIN_C1 = 15'd25736;
  localparam logic [13:0] SIN_C3 = 14'd10582;
  localparam logic [10:0] SIN_C5 = 11'd1230;

  // oscillator levels, Q12
  localparam logic signed [14:0] OSC_OFFSET = 15'sd4137;
  localparam logic signed [14:0] OSC_IDLE   = 15'sd41;
  // rostral bias weight 1.2, Q12
  localparam logic signed [14:0] BIAS_WEIGHT = 15'sd4915;

  // sigmoid breakpoints and levels, Q12
  localparam logic [29:0] SIGM_SAT   = 30'd20480;
  localparam logic [29:0] SIGM_KNEE2 = 30'd9728;
  localparam logic [29:0] SIGM_KNEE1 = 30'd4096;
  localparam logic [12:0] SIGM_ONE   = 13'd4096;
  localparam logic [12:0] SIGM_OFS2  = 13'd3456;
  localparam logic [12:0] SIGM_OFS1  = 13'd2560;
  localparam logic [12:0] SIGM_OFS0  = 13'd2048;

  // pipeline: issue feeds stage 1, sine unit covers stages 1..4, result in stage 10
  localparam int PIPE_DEPTH = 10;
  localparam int SINE_LAT   = 4;

  typedef struct packed {
    logic signed [15:0] amp_l;
    logic signed [15:0] amp_r;
    logic signed [15:0] bias_l;
    logic signed [15:0] bias_r;
    logic signed [15:0] drive_l;
    logic signed [15:0] drive_r;
    logic               bout;
  } item_t;

  // phase offset of a segment: round(seg * 65536 / 10) modulo one turn
  function automatic logic [15:0] seg_offset(input logic [3:0] seg);
    logic [15:0] off;
    case (seg)
      4'd0, 4'd10: off = 16'd0;
      4'd1, 4'd11: off = 16'd6554;
      4'd2, 4'd12: off = 16'd13107;
      4'd3, 4'd13: off = 16'd19661;
      4'd4, 4'd14: off = 16'd26214;
      4'd5, 4'd15: off = 16'd32768;
      4'd6:        off = 16'd39322;
      4'd7:        off = 16'd45875;
      4'd8:        off = 16'd52429;
      4'd9:        off = 16'd58982;
      default:     off = 16'd0;
    endcase
    return off;
  endfunction

endpackage
`default_nettype wire

// File: hdl/smt_sine.sv
// Four-stage pipelined sine of a 16-bit turn fraction, Q12 result.
`default_nettype none
module smt_sine (
  input  wire                clk,
  input  wire                en,
  input  wire         [15:0] angle,
  output logic signed [13:0] sine
);

  logic [14:0] x;
  logic [29:0] sq;
  logic [30:0] sq_rnd;

  logic [14:0] x_a_r, x2_a_r;
  logic        neg_a_r;
  logic [14:0] x_b_r;
  logic [13:0] t1_b_r;
  logic [14:0] x2_b_r;
  logic        neg_b_r;
  logic [14:0] x_c_r, t2_c_r;
  logic        neg_c_r;
  logic signed [13:0] sine_r;

  logic [25:0] c5p;
  logic [26:0] c5p_rnd;
  logic [28:0] t1p;
  logic [29:0] t1p_rnd;
  logic [29:0] sp;
  logic [30:0] sp_rnd;
  logic [16:0] s;
  logic [17:0] s_rnd;
  logic [15:0] v;
  logic [12:0] v_clip;

  // fold into the first quadrant
  assign x      = angle[14] ? (15'd16384 - {1'b0, angle[13:0]}) : {1'b0, angle[13:0]};
  assign sq     = 30'(x) * 30'(x);
  assign sq_rnd = {1'b0, sq} + 31'd8192;

  assign c5p     = 26'(x2_a_r) * 26'(smt_pkg::SIN_C5);
  assign c5p_rnd = {1'b0, c5p} + 27'd8192;

  assign t1p     = 29'(x2_b_r) * 29'(t1_b_r);
  assign t1p_rnd = {1'b0, t1p} + 30'd8192;

  assign sp     = 30'(x_c_r) * 30'(t2_c_r);
  assign sp_rnd = {1'b0, sp} + 31'd8192;
  assign s      = sp_rnd[30:14];
  assign s_rnd  = {1'b0, s} + 18'd2;
  assign v      = s_rnd[17:2];
  assign v_clip = (v > 16'd4096) ? 13'd4096 : v[12:0];

  always_ff @(posedge clk) begin
    if (en) begin
      x_a_r   <= x;
      x2_a_r  <= sq_rnd[28:14];
      neg_a_r <= angle[15];

      x_b_r   <= x_a_r;
      x2_b_r  <= x2_a_r;
      t1_b_r  <= smt_pkg::SIN_C3 - {1'b0, c5p_rnd[26:14]};
      neg_b_r <= neg_a_r;

      x_c_r   <= x_b_r;
      t2_c_r  <= smt_pkg::SIN_C1 - t1p_rnd[28:14];
      neg_c_r <= neg_b_r;

      sine_r  <= neg_c_r ? -$signed({1'b0, v_clip}) : $signed({1'b0, v_clip});
    end
  end

  assign sine = sine_r;

endmodule
`default_nettype wire

// File: hdl/swim_oscillator_motor_targets_core.sv
// Top level of the swim motor target generator: issue, neuron pipeline, config registers.
`default_nettype none
// Each accepted input transfer (one control tick) produces SEGMENTS output transfers,
// one per tail segment in order 0..SEGMENTS-1, the last one flagged by out_tlast. A
// segment counter walks the held item through a single ten-stage pipeline (sine,
// oscillator products, neuron drive, sigmoid gain, sigmoid, segment gain, output), so
// the block sustains one result per cycle while the output is not stalled and takes
// a new item once the held one has issued all SEGMENTS segments (6 by default), the next
// one in the same cycle that its predecessor issues its last segment. A stall on the
// output freezes the whole pipeline; nothing is dropped or repeated. Configuration
// writes (cfg_ready is always high) must only happen while the block is idle; unknown
// register indexes are ignored. in_tuser[1] (first bend side) has no effect.
module swim_oscillator_motor_targets_core #(
  parameter int SEGMENTS = 6
) (
  input  wire          clk,
  input  wire          rst_n,
  // input item
  input  wire          in_tvalid,
  output logic         in_tready,
  // [15:0] amp_left, [31:16] amp_right, [47:32] bias_left, [63:48] bias_right,
  // [79:64] drive_left, [95:80] drive_right, [111:96] phase_turns
  input  wire  [111:0] in_tdata,
  // [0] in_bout, [1] bend_side
  input  wire  [1:0]   in_tuser,
  // results
  output logic         out_tvalid,
  input  wire          out_tready,
  // [15:0] target_angle
  output logic [15:0]  out_tdata,
  // [2:0] segment
  output logic [2:0]   out_tuser,
  output logic         out_tlast,
  // configuration write
  input  wire          cfg_valid,
  output logic         cfg_ready,
  input  wire  [7:0]   cfg_addr,
  input  wire  [15:0]  cfg_data
);

  localparam int IdxW  = (SEGMENTS > 1) ? $clog2(SEGMENTS) : 1;
  localparam int Depth = smt_pkg::PIPE_DEPTH;
  localparam int SLat  = smt_pkg::SINE_LAT;

  // ---------------- configuration registers ----------------
  logic        [15:0] sig_gain_r;
  logic signed [15:0] sig_bias_r;
  logic        [14:0] seg_gain_r [smt_pkg::GAIN_REGS];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sig_gain_r <= 16'd256;
      sig_bias_r <= '0;
      for (int g = 0; g < smt_pkg::GAIN_REGS; g++) seg_gain_r[g] <= 15'd4096;
    end else if (cfg_valid) begin
      unique case (cfg_addr) inside
        smt_pkg::CFG_SIG_GAIN: sig_gain_r <= cfg_data;
        smt_pkg::CFG_SIG_BIAS: sig_bias_r <= $signed(cfg_data);
        [smt_pkg::CFG_SEG_GAIN_0:smt_pkg::CFG_SEG_GAIN_LAST]:
          seg_gain_r[3'(cfg_addr - smt_pkg::CFG_SEG_GAIN_0)] <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  // ---------------- item buffer and segment issue ----------------
  smt_pkg::item_t  item_r;
  logic [15:0]     phase_r;
  logic            item_vld_r, item_vld_nxt;
  logic [IdxW-1:0] seg_cnt_r, seg_cnt_nxt;
  logic [Depth:1]  vld_r;
  logic            adv, issue, last_issue, in_xfer;

  assign adv        = !vld_r[Depth] || out_tready;   // whole pipeline moves together
  assign issue      = item_vld_r && adv;
  assign last_issue = (seg_cnt_r == IdxW'(SEGMENTS - 1));
  assign in_tready  = !item_vld_r || (adv && last_issue);
  assign in_xfer    = in_tvalid && in_tready;

  always_comb begin
    item_vld_nxt = item_vld_r;
    seg_cnt_nxt  = seg_cnt_r;
    if (issue) begin
      seg_cnt_nxt = last_issue ? '0 : seg_cnt_r + 1'b1;
      if (last_issue) item_vld_nxt = 1'b0;
    end
    if (in_xfer) item_vld_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
      seg_cnt_r  <= '0;
    end else begin
      item_vld_r <= item_vld_nxt;
      seg_cnt_r  <= seg_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      item_r.amp_l   <= $signed(in_tdata[15:0]);
      item_r.amp_r   <= $signed(in_tdata[31:16]);
      item_r.bias_l  <= $signed(in_tdata[47:32]);
      item_r.bias_r  <= $signed(in_tdata[63:48]);
      item_r.drive_l <= $signed(in_tdata[79:64]);
      item_r.drive_r <= $signed(in_tdata[95:80]);
      item_r.bout    <= in_tuser[0];
      phase_r        <= in_tdata[111:96];
    end
  end

  // valid bits, one per stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[Depth-1:1], item_vld_r};
    end
  end

  // item and segment tags ride alongside the data
  smt_pkg::item_t  item_p_r [1:SLat];
  logic [IdxW-1:0] idx_p_r  [1:Depth-1];

  always_ff @(posedge clk) begin
    if (adv) begin
      item_p_r[1] <= item_r;
      idx_p_r[1]  <= seg_cnt_r;
      for (int k = 2; k <= SLat; k++) item_p_r[k] <= item_p_r[k-1];
      for (int k = 2; k <= Depth - 1; k++) idx_p_r[k] <= idx_p_r[k-1];
    end
  end

  // ---------------- stages 1..4: sine ----------------
  logic [15:0]        angle;
  logic signed [13:0] sine_v;

  assign angle = phase_r + smt_pkg::seg_offset(4'(seg_cnt_r));

  smt_sine u_sine (
    .clk   (clk),
    .en    (adv),
    .angle (angle),
    .sine  (sine_v)
  );

  // ---------------- stage 5: oscillators and products ----------------
  // right oscillator is half a turn behind: same magnitude, opposite sign
  logic signed [14:0] osc_l, osc_r;
  logic signed [30:0] p_l_r, p_r_r, pb_l_r, pb_r_r;
  logic signed [15:0] drv_l_r, drv_r_r;

  assign osc_l = item_p_r[SLat].bout ? (smt_pkg::OSC_OFFSET + 15'(sine_v)) : smt_pkg::OSC_IDLE;
  assign osc_r = item_p_r[SLat].bout ? (smt_pkg::OSC_OFFSET - 15'(sine_v)) : smt_pkg::OSC_IDLE;

  always_ff @(posedge clk) begin
    if (adv) begin
      p_l_r   <= 31'(item_p_r[SLat].amp_l) * 31'(osc_l);
      p_r_r   <= 31'(item_p_r[SLat].amp_r) * 31'(osc_r);
      pb_l_r  <= 31'(item_p_r[SLat].bias_l) * 31'(smt_pkg::BIAS_WEIGHT);
      pb_r_r  <= 31'(item_p_r[SLat].bias_r) * 31'(smt_pkg::BIAS_WEIGHT);
      drv_l_r <= item_p_r[SLat].drive_l;
      drv_r_r <= item_p_r[SLat].drive_r;
    end
  end

  // ---------------- stage 6: neuron drive minus threshold ----------------
  logic               rostral;
  logic signed [30:0] pl_rnd, pr_rnd, pbl_rnd, pbr_rnd;
  logic signed [20:0] u_l, u_r;
  logic signed [20:0] d_l_r, d_r_r;

  assign rostral = (5'(idx_p_r[5]) < 5'd2);   // segments 0 and 1 get the bias term
  assign pl_rnd  = (p_l_r + 31'sd2048) >>> 12;
  assign pr_rnd  = (p_r_r + 31'sd2048) >>> 12;
  assign pbl_rnd = (pb_l_r + 31'sd2048) >>> 12;
  assign pbr_rnd = (pb_r_r + 31'sd2048) >>> 12;
  assign u_l = 21'(pl_rnd) + (21'(drv_l_r) <<< 1) + (rostral ? 21'(pbl_rnd) : 21'sd0);
  assign u_r = 21'(pr_rnd) + (21'(drv_r_r) <<< 1) + (rostral ? 21'(pbr_rnd) : 21'sd0);

  always_ff @(posedge clk) begin
    if (adv) begin
      d_l_r <= u_l - 21'(sig_bias_r);
      d_r_r <= u_r - 21'(sig_bias_r);
    end
  end

  // ---------------- stage 7: sigmoid steepness ----------------
  logic signed [16:0] gain_s;
  logic signed [37:0] zp_l, zp_r;
  logic signed [29:0] z_l_r, z_r_r;

  assign gain_s = $signed({1'b0, sig_gain_r});
  assign zp_l   = (38'(d_l_r) * 38'(gain_s) + 38'sd128) >>> 8;
  assign zp_r   = (38'(d_r_r) * 38'(gain_s) + 38'sd128) >>> 8;

  always_ff @(posedge clk) begin
    if (adv) begin
      z_l_r <= 30'(zp_l);
      z_r_r <= 30'(zp_r);
    end
  end

  // ---------------- stage 8: piecewise linear sigmoid ----------------
  function automatic logic [12:0] sigm_q12(input logic signed [29:0] z);
    logic [29:0] a;
    logic [12:0] y;
    a = z[29] ? $unsigned(-z) : $unsigned(z);
    if (a >= smt_pkg::SIGM_SAT)        y = smt_pkg::SIGM_ONE;
    else if (a >= smt_pkg::SIGM_KNEE2) y = 13'(a >> 5) + smt_pkg::SIGM_OFS2;
    else if (a >= smt_pkg::SIGM_KNEE1) y = 13'(a >> 3) + smt_pkg::SIGM_OFS1;
    else                               y = 13'(a >> 2) + smt_pkg::SIGM_OFS0;
    return z[29] ? (smt_pkg::SIGM_ONE - y) : y;
  endfunction

  logic [12:0]        sg_l, sg_r;
  logic signed [13:0] diff_r;

  assign sg_l = sigm_q12(z_l_r);
  assign sg_r = sigm_q12(z_r_r);

  always_ff @(posedge clk) begin
    if (adv) diff_r <= $signed({1'b0, sg_r}) - $signed({1'b0, sg_l});
  end

  // ---------------- stage 9: segment gain ----------------
  logic [4:0]  idx9;
  logic [2:0]  gsel;
  logic signed [29:0] prod_r;

  assign idx9 = 5'(idx_p_r[8]);
  assign gsel = (idx9 >= 5'd5) ? 3'd5 : idx9[2:0];   // tail segments share the last gain

  always_ff @(posedge clk) begin
    if (adv) prod_r <= 30'(diff_r) * 30'($signed({1'b0, seg_gain_r[gsel]}));
  end

  // ---------------- stage 10: x2.25, round, saturate ----------------
  logic [4:0]         idx10;
  logic signed [33:0] p9, t;
  logic [15:0]        angle_r;
  logic [2:0]         seg_r;
  logic               last_r;

  assign idx10 = 5'(idx_p_r[Depth-1]);
  assign p9    = (34'(prod_r) <<< 3) + 34'(prod_r);
  assign t     = (p9 + 34'sd8192) >>> 14;

  always_ff @(posedge clk) begin
    if (adv) begin
      if (t > 34'sd32767)       angle_r <= 16'h7FFF;
      else if (t < -34'sd32768) angle_r <= 16'h8000;
      else                      angle_r <= t[15:0];
      seg_r  <= idx10[2:0];
      last_r <= (idx_p_r[Depth-1] == IdxW'(SEGMENTS - 1));
    end
  end

  assign out_tvalid = vld_r[Depth];
  assign out_tdata  = angle_r;
  assign out_tuser  = seg_r;
  assign out_tlast  = last_r;

`ifndef SYNTHESIS
  a_last_is_final_seg: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tuser == 3'(SEGMENTS - 1))
    else $error("last flag on a segment other than the final one");

  a_seg_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    item_vld_r |-> seg_cnt_r <= IdxW'(SEGMENTS - 1))
    else $error("segment counter past final segment");

  a_load_starts_run: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> item_vld_r && seg_cnt_r == '0)
    else $error("accepted item not started at segment zero");

  a_stall_freezes: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(vld_r) && $stable(seg_cnt_r))
    else $error("pipeline moved during output stall");
`endif

endmodule
`default_nettype wire

// File: test/tb_swim_oscillator_motor_targets_core.sv
// Self-checking testbench for the swim motor target generator core.
module tb_swim_oscillator_motor_targets_core;

  localparam int SEGS           = 6;
  localparam int GAIN_SLOTS     = 6;
  localparam int LONG_HOLD      = 300;   // output held off this long once
  localparam int WATCHDOG_LIMIT = 3000;  // quiet cycles before giving up
  localparam int TAIL_CYCLES    = 4 * smt_pkg::PIPE_DEPTH;

  // Q12 / Q14 figures the predictor works with
  localparam longint ONE_Q12   = 4096;
  localparam longint OSC_RUN   = 4137;  // 1.01
  localparam longint OSC_REST  = 41;    // 0.01
  localparam longint ROSTRAL_W = 4915;  // 1.2
  localparam int unsigned POLY_C1 = 25736;
  localparam int unsigned POLY_C3 = 10582;
  localparam int unsigned POLY_C5 = 1230;

  // one control tick as accepted on the input stream
  typedef struct {
    smt_pkg::item_t body;
    logic [15:0]    phase;
    logic           bend;
  } tick_t;

  // one segment target as seen on the output stream
  typedef struct {
    logic [2:0]  seg;
    logic [15:0] angle;
    logic        last;
  } target_t;

  // Predicts segment targets per tick and checks them in order.
  class target_book;
    longint  sig_gain;
    longint  sig_bias;
    longint  seg_gain[GAIN_SLOTS];
    target_t due_targets[$];
    int      ticks_seen;
    int      targets_checked;
    int      cfg_writes;
    int      errors;

    function new();
      sig_gain = 256;
      sig_bias = 0;
      foreach (seg_gain[k]) seg_gain[k] = 4096;
    endfunction

    function void write_reg(logic [7:0] addr, logic [15:0] data);
      cfg_writes++;
      if (addr == smt_pkg::CFG_SIG_GAIN)
        sig_gain = data;
      else if (addr == smt_pkg::CFG_SIG_BIAS)
        sig_bias = longint'($signed(data));
      else if (addr >= smt_pkg::CFG_SEG_GAIN_0 && addr <= smt_pkg::CFG_SEG_GAIN_LAST)
        seg_gain[addr - smt_pkg::CFG_SEG_GAIN_0] = data[14:0];
      // any other index is dropped by the block
    endfunction

    // divide by 2^n, rounding half toward plus infinity
    function longint rnd_shift(longint v, int n);
      return (v + (longint'(1) <<< (n - 1))) >>> n;
    endfunction

    // polynomial sine over a 16-bit turn fraction, Q12
    function longint sine_q12(int unsigned ang);
      int unsigned a, quad, r, x, x2, t, s;
      int v;
      a    = ang & 32'hFFFF;
      quad = a >> 14;
      r    = a & 32'h3FFF;
      x    = quad[0] ? 16384 - r : r;
      x2   = (x * x + 8192) >> 14;
      t    = POLY_C3 - ((x2 * POLY_C5 + 8192) >> 14);
      t    = POLY_C1 - ((x2 * t + 8192) >> 14);
      s    = (x * t + 8192) >> 14;
      v    = int'((s + 2) >> 2);
      if (v > 4096) v = 4096;
      return quad[1] ? -v : v;
    endfunction

    // piecewise linear sigmoid, Q12 in 0..4096
    function longint sigmoid_q12(longint z);
      longint a, y;
      a = (z < 0) ? -z : z;
      if (a >= 20480)     y = ONE_Q12;
      else if (a >= 9728) y = a / 32 + 3456;
      else if (a >= 4096) y = a / 8 + 2560;
      else                y = a / 4 + 2048;
      if (y > ONE_Q12) y = ONE_Q12;
      return (z < 0) ? ONE_Q12 - y : y;
    endfunction

    function longint neuron_level(longint amp, longint osc, longint bias,
                                  longint drive, bit rostral);
      longint u;
      u = rnd_shift(amp * osc, 12) + 2 * drive;
      if (rostral) u += rnd_shift(bias * ROSTRAL_W, 12);
      return sigmoid_q12(rnd_shift(sig_gain * (u - sig_bias), 8));
    endfunction

    function void note_tick(tick_t t);
      longint osc_l, osc_r, lft, rgt, ang_t;
      int unsigned off, ang;
      int i, gi;
      target_t due;
      ticks_seen++;
      for (i = 0; i < SEGS; i++) begin
        // outside a bout both oscillators rest at 0.01
        osc_l = OSC_REST;
        osc_r = OSC_REST;
        if (t.body.bout) begin
          off   = (i * 65536 + 5) / 10;
          ang   = (t.phase + off) & 32'hFFFF;
          osc_l = sine_q12(ang) + OSC_RUN;
          osc_r = sine_q12((ang + 32768) & 32'hFFFF) + OSC_RUN;
        end
        lft = neuron_level(longint'(t.body.amp_l), osc_l, longint'(t.body.bias_l),
                           longint'(t.body.drive_l), i < 2);
        rgt = neuron_level(longint'(t.body.amp_r), osc_r, longint'(t.body.bias_r),
                           longint'(t.body.drive_r), i < 2);
        gi    = (i < GAIN_SLOTS) ? i : GAIN_SLOTS - 1;
        ang_t = rnd_shift((rgt - lft) * seg_gain[gi] * 9, 14);
        if (ang_t > 32767)  ang_t = 32767;
        if (ang_t < -32768) ang_t = -32768;
        due.seg   = i[2:0];
        due.angle = ang_t[15:0];
        due.last  = (i == SEGS - 1);
        due_targets.push_back(due);
      end
    endfunction

    function void check_target(logic [2:0] seg, logic [15:0] angle, logic last);
      target_t due;
      targets_checked++;
      if (due_targets.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected target: segment %0d angle %0d last %0b",
                   seg, $signed(angle), last);
        return;
      end
      due = due_targets.pop_front();
      if (seg !== due.seg || angle !== due.angle || last !== due.last) begin
        errors++;
        if (errors <= 10)
          $display("target mismatch: segment %0d/%0d angle %0d/%0d last %0b/%0b (exp/got)",
                   due.seg, seg, $signed(due.angle), $signed(angle), due.last, last);
      end
    endfunction

    function int pending_count();
      return due_targets.size();
    endfunction
  endclass

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [111:0] in_tdata = '0;
  logic [1:0]   in_tuser = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [15:0]  out_tdata;
  logic [2:0]   out_tuser;
  logic         out_tlast;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [7:0]   cfg_addr = '0;
  logic [15:0]  cfg_data = '0;

  target_book book = new();
  int  ticks_sent;
  int  quiet_cycles;
  int  settings_run;
  bit  tx_idle;
  bit  rx_idle;
  bit  hold_req;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  swim_oscillator_motor_targets_core #(.SEGMENTS(SEGS)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_addr   (cfg_addr),
    .cfg_data   (cfg_data)
  );

  // Bus monitor: every transfer is taken from the pins, so the predictor
  // works on exactly what the block accepted.
  always @(posedge clk) begin : bus_watch
    tick_t seen;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) book.write_reg(cfg_addr, cfg_data);
      if (in_tvalid && in_tready) begin
        seen.body.amp_l   = in_tdata[15:0];
        seen.body.amp_r   = in_tdata[31:16];
        seen.body.bias_l  = in_tdata[47:32];
        seen.body.bias_r  = in_tdata[63:48];
        seen.body.drive_l = in_tdata[79:64];
        seen.body.drive_r = in_tdata[95:80];
        seen.phase        = in_tdata[111:96];
        seen.body.bout    = in_tuser[0];
        seen.bend         = in_tuser[1];
        book.note_tick(seen);
      end
      if (out_tvalid && out_tready) book.check_target(out_tuser, out_tdata, out_tlast);
    end
  end

  // Watchdog on cycles where no channel moves a transfer.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles, %0d targets outstanding",
               quiet_cycles, book.pending_count());
      $display("Verification failed");
      $finish;
    end else
      quiet_cycles <= quiet_cycles + 1;
  end

  // Result side: random ready gaps per result, plus one long hold-off on
  // request so that the pipeline backs up into the input.
  initial begin : result_side
    int w;
    wait (rst_n);
    forever begin
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_req = 1'b0;
      end
      w = rx_idle ? $urandom_range(0, 13) : 0;
      if (w > 0) begin
        out_tready <= 1'b0;
        repeat (w) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid && !hold_req);
    end
  end

  function automatic tick_t mk_tick(int al, int ar, int bl, int br, int dl, int dr,
                                    bit bout, bit bend, int phase);
    tick_t t;
    t.body.amp_l   = al[15:0];
    t.body.amp_r   = ar[15:0];
    t.body.bias_l  = bl[15:0];
    t.body.bias_r  = br[15:0];
    t.body.drive_l = dl[15:0];
    t.body.drive_r = dr[15:0];
    t.body.bout    = bout;
    t.bend         = bend;
    t.phase        = phase[15:0];
    return t;
  endfunction

  // mostly values inside the sigmoid's working range, some full range
  function automatic logic [15:0] pick_word(int span);
    int v;
    case ($urandom_range(0, 7))
      0: v = $urandom_range(0, 65535);
      1: v = $urandom_range(0, 1) ? 32767 : -32768;
      default: v = int'($urandom_range(0, 2 * span)) - span;
    endcase
    return v[15:0];
  endfunction

  function automatic tick_t rand_tick();
    tick_t t;
    t.body.amp_l   = pick_word(16384);
    t.body.amp_r   = pick_word(16384);
    t.body.bias_l  = pick_word(4000);
    t.body.bias_r  = pick_word(4000);
    t.body.drive_l = pick_word(3000);
    t.body.drive_r = pick_word(3000);
    t.body.bout    = ($urandom_range(0, 3) != 0);
    t.bend         = 1'($urandom_range(0, 1));
    t.phase        = 16'($urandom_range(0, 65535));
    return t;
  endfunction

  task automatic send_tick(tick_t t);
    int gap;
    gap = tx_idle ? $urandom_range(0, 13) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {t.phase, t.body.drive_r, t.body.drive_l, t.body.bias_r,
                  t.body.bias_l, t.body.amp_r, t.body.amp_l};
    in_tuser  <= {t.bend, t.body.bout};
    do @(posedge clk); while (!in_tready);
    ticks_sent++;
  endtask

  // leaves cfg_valid high; the caller drops it after the last write
  task automatic cfg_write(logic [7:0] addr, logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_addr  <= addr;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // every tick yields results, so the block is idle once all have arrived
  task automatic drain();
    in_tvalid <= 1'b0;
    while (book.ticks_seen < ticks_sent || book.pending_count() != 0) @(posedge clk);
  endtask

  initial begin : stimulus
    tick_t dq[$];
    int    ph, k, n;
    int    v;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed ticks at reset settings.
    dq.push_back(mk_tick(0, 0, 0, 0, 0, 0, 0, 0, 0));        // resting oscillators
    dq.push_back(mk_tick(0, 0, 0, 0, 0, 0, 1, 0, 0));
    // quadrant edges of the phase
    dq.push_back(mk_tick(4096, 4096, 0, 0, 0, 0, 1, 0, 16'h0000));
    dq.push_back(mk_tick(4096, 4096, 0, 0, 0, 0, 1, 0, 16'h3FFF));
    dq.push_back(mk_tick(4096, 4096, 0, 0, 0, 0, 1, 0, 16'h4000));
    dq.push_back(mk_tick(8192, 2048, 0, 0, 0, 0, 1, 0, 16'h8000));
    dq.push_back(mk_tick(8192, 2048, 0, 0, 0, 0, 1, 0, 16'hFFFF));
    // amplitude and rostral bias extremes
    dq.push_back(mk_tick(32767, -32768, 0, 0, 0, 0, 1, 0, 1234));
    dq.push_back(mk_tick(-32768, 32767, 0, 0, 0, 0, 1, 0, 50000));
    dq.push_back(mk_tick(0, 0, 32767, -32768, 0, 0, 1, 0, 777));
    dq.push_back(mk_tick(0, 0, -32768, 32767, 0, 0, 0, 0, 777));
    // large neuron drive, kept wide until the final angle
    dq.push_back(mk_tick(0, 0, 0, 0, 32767, -32768, 1, 0, 0));
    dq.push_back(mk_tick(0, 0, 0, 0, -32768, 32767, 0, 1, 0));
    // straddle each sigmoid knee
    dq.push_back(mk_tick(0, 0, 0, 0, 2047, 2048, 0, 0, 0));
    dq.push_back(mk_tick(0, 0, 0, 0, 4863, 4864, 0, 0, 0));
    dq.push_back(mk_tick(0, 0, 0, 0, 10239, 10240, 0, 0, 0));
    dq.push_back(mk_tick(0, 0, 0, 0, -2048, -10240, 0, 0, 0));
    // first bend side must not matter: same tick with the flag flipped
    dq.push_back(mk_tick(8000, -3000, 1500, -700, 1000, -900, 1, 0, 9999));
    dq.push_back(mk_tick(8000, -3000, 1500, -700, 1000, -900, 1, 1, 9999));
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    foreach (dq[i]) send_tick(dq[i]);
    drain();
    settings_run = 1;

    for (ph = 1; ph <= 9; ph++) begin
      // register writes only while idle
      case (ph)
        1: begin
          // steepest sigmoid, highest threshold, full segment gain
          cfg_write(smt_pkg::CFG_SIG_GAIN, 16'hFFFF);
          cfg_write(smt_pkg::CFG_SIG_BIAS, 16'h7FFF);
          for (k = 0; k < GAIN_SLOTS; k++)
            cfg_write(8'(smt_pkg::CFG_SEG_GAIN_0 + k), 16'h7FFF);
        end
        2: begin
          // flat sigmoid, lowest threshold, zero segment gain
          cfg_write(smt_pkg::CFG_SIG_GAIN, 16'h0000);
          cfg_write(smt_pkg::CFG_SIG_BIAS, 16'h8000);
          for (k = 0; k < GAIN_SLOTS; k++)
            cfg_write(8'(smt_pkg::CFG_SEG_GAIN_0 + k), 16'h0000);
        end
        default: begin
          v = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                          : $urandom_range(32, 1024);
          cfg_write(smt_pkg::CFG_SIG_GAIN, v[15:0]);
          v = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                          : int'($urandom_range(0, 12000)) - 6000;
          cfg_write(smt_pkg::CFG_SIG_BIAS, v[15:0]);
          for (k = 0; k < GAIN_SLOTS; k++) begin
            v = ($urandom_range(0, 5) == 0) ? 32767 : $urandom_range(0, 32767);
            cfg_write(8'(smt_pkg::CFG_SEG_GAIN_0 + k), v[15:0]);
          end
        end
      endcase
      // a write to an index past the gain slots must change nothing
      v = $urandom_range(int'(smt_pkg::CFG_SEG_GAIN_LAST) + 1, 255);
      cfg_write(v[7:0], 16'($urandom_range(0, 65535)));
      cfg_valid <= 1'b0;
      settings_run++;

      // phase 3 backs the block up under a long output hold-off;
      // phase 4 runs both sides at full rate
      tx_idle = (ph == 3 || ph == 4) ? 1'b0 : $urandom_range(0, 1);
      rx_idle = (ph == 4) ? 1'b0 : $urandom_range(0, 1);
      if (ph == 3) hold_req = 1'b1;

      n = (ph <= 2) ? 20 : 60;
      if (ph == 1) begin
        // full gain drives the angle into both saturation rails
        send_tick(mk_tick(0, 0, 0, 0, -32768, 32767, 1, 0, 0));
        send_tick(mk_tick(0, 0, 0, 0, 32767, -32768, 0, 0, 0));
      end
      repeat (n) send_tick(rand_tick());
      drain();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Run covered %0d ticks and %0d segment targets across %0d register settings,",
             book.ticks_seen, book.targets_checked, settings_run);
    $display("with random gaps on both streams and one %0d-cycle output hold; %0d errors.",
             LONG_HOLD, book.errors);
    if (book.errors == 0 && book.pending_count() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
